// File: rtl/core/cbm_pkg.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Shared types, command codes, mapper codes and register indexes.
// ----------------------------------------------------------------------------
package cbm_pkg;

	localparam logic [1:0] CMD_PRG_WRITE = 2'd0;
	localparam logic [1:0] CMD_CHR_READ  = 2'd1;
	localparam logic [1:0] CMD_PRG_LOW   = 2'd2;
	localparam logic [1:0] CMD_PRG_HIGH  = 2'd3;

	localparam logic [7:0] MAPPER_SERIAL = 8'd1;
	localparam logic [7:0] MAPPER_LATCH  = 8'd2;

	localparam logic [2:0] CFG_MAPPER_TYPE    = 3'd0;
	localparam logic [2:0] CFG_PRG_BANK_COUNT = 3'd1;
	localparam logic [2:0] CFG_CHR_SIZE_BYTES = 3'd2;
	localparam logic [2:0] CFG_CHR_LOW_PAGE   = 3'd3;
	localparam logic [2:0] CFG_CHR_HIGH_PAGE  = 3'd4;

	localparam logic [1:0] MIRROR_SWAP_LOW  = 2'd2;
	localparam logic [1:0] MIRROR_SWAP_HIGH = 2'd3;

	localparam logic [1:0] SREG_CONTROL = 2'd0;
	localparam logic [1:0] SREG_CHR0    = 2'd1;
	localparam logic [1:0] SREG_CHR1    = 2'd2;

	localparam logic [2:0] SHIFT_LAST = 3'd4;

	localparam logic [8:0] PAGE_NONE = 9'h1FF;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [14:0] bus_addr;
		logic [7:0]  write_byte;
	} cbm_in_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] rom_addr;
		logic        blank_read;
		logic        reg_loaded;
		logic [1:0]  mirror_mode;
	} cbm_out_t;

	typedef struct packed {
		logic [7:0]        mapper_type;
		logic [7:0]        prg_bank_count;
		logic [15:0]       chr_size_bytes;
		logic signed [8:0] chr_low_page;
		logic signed [8:0] chr_high_page;
	} cbm_cfg_t;

	typedef struct packed {
		logic [1:0] mirror;
		logic [3:0] chr0;
		logic [3:0] chr1;
	} cbm_banks_t;

	typedef struct packed {
		logic       ok;
		logic       loaded;
		logic [1:0] mirror_next;
	} cbm_wr_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] rom_addr;
		logic        blank_read;
	} cbm_rd_t;

endpackage

// File: rtl/core/cartridge_bank_mapper_core.sv
// A transaction accepted into the input register moves on to the result register.
// Throughput: one transaction per cycle while out_stall is low; the input
// register, one level of translation logic and the result register set it.
// Reset: arst_n clears both stage valids, the serial loader state and the
// configuration registers; the page overrides reset to the mapper bank path.
// ----------------------------------------------------------------------------
// Cartridge bank mapper core
// Input register, serial loader, read translation and result register.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cbm_pkg::cbm_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output cbm_pkg::cbm_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	logic                valid_s1;
	cbm_pkg::cbm_in_t    item_s1;
	logic                valid_s2;
	cbm_pkg::cbm_out_t   result_s2;
	logic                advance;
	logic                is_write;
	cbm_pkg::cbm_cfg_t   cfg;
	cbm_pkg::cbm_wr_t    wr;
	cbm_pkg::cbm_banks_t banks;
	cbm_pkg::cbm_rd_t    rd;
	cbm_pkg::cbm_out_t   result;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign is_write = (item_s1.cmd == cbm_pkg::CMD_PRG_WRITE);

	cbm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cbm_serial u_serial (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance && is_write),
		.item        (item_s1),
		.mapper_type (cfg.mapper_type),
		.wr          (wr),
		.banks       (banks)
	);

	cbm_xlate u_xlate (
		.item  (item_s1),
		.cfg   (cfg),
		.banks (banks),
		.rd    (rd)
	);

	always_comb begin
		result.mirror_mode = wr.mirror_next;
		if (is_write) begin
			result.ok         = wr.ok;
			result.rom_addr   = 16'd0;
			result.blank_read = 1'b0;
			result.reg_loaded = wr.loaded;
		end else begin
			result.ok         = rd.ok;
			result.rom_addr   = rd.rom_addr;
			result.blank_read = rd.blank_read;
			result.reg_loaded = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("Accepted transaction did not reach the input register.");

	a_advance_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (valid_s2 && result_s2 == $past(result)))
		else $error("Result register did not capture the advancing transaction.");

	a_blank_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.blank_read) |->
		(out_data.ok && out_data.rom_addr == 16'd0 && !out_data.reg_loaded))
		else $error("Blank character read carried an address or a load.");

	a_loaded_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.reg_loaded) |-> (out_data.ok && out_data.rom_addr == 16'd0))
		else $error("Register load reported on a failed or read transaction.");

endmodule

// File: rtl/core/cbm_cfg.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper configuration registers
// Holds the mapper type, bank count, character size and page overrides.
// ----------------------------------------------------------------------------
module cbm_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output cbm_pkg::cbm_cfg_t  cfg
);

	cbm_pkg::cbm_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mapper_type    <= 8'd0;
			cfg_q.prg_bank_count <= 8'd0;
			cfg_q.chr_size_bytes <= 16'd0;
			cfg_q.chr_low_page   <= cbm_pkg::PAGE_NONE;
			cfg_q.chr_high_page  <= cbm_pkg::PAGE_NONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cbm_pkg::CFG_MAPPER_TYPE:    cfg_q.mapper_type    <= cfg_data[7:0];
				cbm_pkg::CFG_PRG_BANK_COUNT: cfg_q.prg_bank_count <= cfg_data[7:0];
				cbm_pkg::CFG_CHR_SIZE_BYTES: cfg_q.chr_size_bytes <= cfg_data;
				cbm_pkg::CFG_CHR_LOW_PAGE:   cfg_q.chr_low_page   <= cfg_data[8:0];
				cbm_pkg::CFG_CHR_HIGH_PAGE:  cfg_q.chr_high_page  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/core/cbm_serial.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper serial loader
// Shifts program write data in one bit at a time; the fifth write commits the first four.
// ----------------------------------------------------------------------------
module cbm_serial (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  cbm_pkg::cbm_in_t    item,
	input  logic [7:0]          mapper_type,
	output cbm_pkg::cbm_wr_t    wr,
	output cbm_pkg::cbm_banks_t banks
);

	logic [3:0] shift_q;
	logic [2:0] count_q;
	logic [1:0] ctrl_q;
	logic [3:0] chr0_q;
	logic [3:0] chr1_q;
	logic       serial_sel;
	logic       clear;
	logic       commit;
	logic [1:0] reg_sel;
	logic [3:0] shift_d;
	logic       upd;

	assign serial_sel = (mapper_type == cbm_pkg::MAPPER_SERIAL);
	assign clear      = item.write_byte[7];
	assign commit     = serial_sel && !clear && (count_q == cbm_pkg::SHIFT_LAST) &&
		(item.cmd == cbm_pkg::CMD_PRG_WRITE);
	assign reg_sel    = item.bus_addr[14:13];
	assign upd        = en && serial_sel;

	always_comb begin
		shift_d = shift_q;
		shift_d[count_q[1:0]] = shift_q[count_q[1:0]] | item.write_byte[0];
	end

	assign wr.ok     = serial_sel || (mapper_type == cbm_pkg::MAPPER_LATCH);
	assign wr.loaded = commit;
	assign wr.mirror_next = (commit && reg_sel == cbm_pkg::SREG_CONTROL) ? shift_q[1:0] : ctrl_q;

	assign banks.mirror = ctrl_q;
	assign banks.chr0   = chr0_q;
	assign banks.chr1   = chr1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 4'd0;
			count_q <= 3'd0;
			ctrl_q  <= 2'd0;
			chr0_q  <= 4'd0;
			chr1_q  <= 4'd0;
		end else if (upd) begin
			if (clear || commit) begin
				shift_q <= 4'd0;
				count_q <= 3'd0;
			end else begin
				shift_q <= shift_d;
				count_q <= count_q + 3'd1;
			end
			if (commit) begin
				case (reg_sel)
					cbm_pkg::SREG_CONTROL: ctrl_q <= shift_q[1:0];
					cbm_pkg::SREG_CHR0:    chr0_q <= shift_q;
					cbm_pkg::SREG_CHR1:    chr1_q <= shift_q;
					default: ;
				endcase
			end
		end
	end

endmodule

// File: rtl/core/cbm_xlate.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper read translation
// Maps character and program reads to ROM addresses and checks the bounds.
// ----------------------------------------------------------------------------
module cbm_xlate (
	input  cbm_pkg::cbm_in_t    item,
	input  cbm_pkg::cbm_cfg_t   cfg,
	input  cbm_pkg::cbm_banks_t banks,
	output cbm_pkg::cbm_rd_t    rd
);

	logic              low;
	logic signed [8:0] page;
	logic [3:0]        bank;
	logic [15:0]       chr_addr;
	logic [15:0]       prg_high_addr;

	assign low  = !item.bus_addr[12];
	assign page = low ? cfg.chr_low_page : cfg.chr_high_page;

	always_comb begin
		if (low) begin
			bank = (banks.mirror == cbm_pkg::MIRROR_SWAP_LOW) ? banks.chr1 : banks.chr0;
		end else begin
			bank = (banks.mirror == cbm_pkg::MIRROR_SWAP_HIGH) ? banks.chr0 : banks.chr1;
		end
	end

	always_comb begin
		if (!page[8]) begin
			chr_addr = {page[5:0], 10'd0} + {4'd0, item.bus_addr[11:0]};
		end else if (cfg.mapper_type == cbm_pkg::MAPPER_SERIAL) begin
			chr_addr = {bank, item.bus_addr[11:0]};
		end else begin
			chr_addr = {4'd0, item.bus_addr[11:0]};
		end
	end

	assign prg_high_addr = {1'b0, item.bus_addr} + 16'h4000;

	always_comb begin
		rd = '0;
		case (item.cmd)
			cbm_pkg::CMD_CHR_READ: begin
				if (item.bus_addr[14:13] != 2'd0) begin
					rd.ok = 1'b1;
					rd.blank_read = 1'b1;
				end else if (chr_addr < cfg.chr_size_bytes) begin
					rd.ok = 1'b1;
					rd.rom_addr = chr_addr;
				end
			end
			cbm_pkg::CMD_PRG_LOW: begin
				if (cfg.prg_bank_count >= 8'd2) begin
					rd.ok = 1'b1;
					rd.rom_addr = {1'b0, item.bus_addr};
				end
			end
			cbm_pkg::CMD_PRG_HIGH: begin
				if (cfg.prg_bank_count >= 8'd2) begin
					rd.ok = 1'b1;
					rd.rom_addr = prg_high_addr;
				end else if (cfg.prg_bank_count == 8'd1) begin
					rd.ok = 1'b1;
					rd.rom_addr = {1'b0, item.bus_addr};
				end
			end
			default: ;
		endcase
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank mapper testbench
// Runs a directed table of program writes, character reads and program reads,
// then random traffic under several register settings with bursty input and
// a stalling receiver, checking results by table row or behavioral predictor.
// ----------------------------------------------------------------------------
module testbench;
	import cbm_pkg::*;

	localparam int unsigned CHR_TABLE_BYTES = 32'h1000;
	localparam int unsigned CHR_WINDOW_END  = 32'h2000;
	localparam int unsigned PAGE_BYTES      = 32'h0400;
	localparam int unsigned BANK_BYTES      = 32'h1000;
	localparam int unsigned PRG_UPPER_BASE  = 32'h4000;
	localparam int unsigned LATCH_LIMIT     = 32'h2000;
	localparam logic [2:0]  CFG_UNUSED      = 3'd7;
	localparam int          DRAIN_CYCLES    = 8;
	localparam int          MAX_REPORTS     = 40;
	localparam int          DIR_ROWS        = 40;
	localparam cbm_out_t    REFUSED         = '0;

	typedef enum logic {ROW_ACCESS, ROW_CONFIG} row_kind_e;
	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_pattern_e;

	typedef struct packed {
		row_kind_e   kind;
		logic [2:0]  index;
		logic [15:0] value;
		cbm_in_t     acc;
		logic        typed;
		cbm_out_t    want;
	} dir_row_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	cbm_in_t     in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	cbm_out_t    out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	cbm_cfg_t       cfg_shadow;
	logic [4:0]     shift_bits;
	logic [2:0]     shift_len;
	logic [4:0]     serial_bank [4];
	logic [4:0]     latched_bank;
	cbm_out_t       expected_results [$];
	cbm_out_t       oldest_result;
	dir_row_t       dir_table [DIR_ROWS];
	stall_pattern_e stall_mode = STALL_NONE;
	int             stall_left = 0;
	int             mismatches = 0;
	int             results_seen = 0;
	int             accesses_sent = 0;
	int             reg_writes = 0;
	int             settings_used = 0;

	cartridge_bank_mapper_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic cbm_out_t translate_access(input cbm_in_t t);
		cbm_out_t    r;
		int unsigned a;
		int unsigned bank;
		logic        low_table;
		logic [8:0]  page;
		logic [1:0]  mirror;
		r = '0;
		case (t.cmd)
			CMD_PRG_WRITE: begin
				if (cfg_shadow.mapper_type == MAPPER_SERIAL) begin
					r.ok = 1'b1;
					if (t.write_byte[7]) begin
						shift_bits = '0;
						shift_len = '0;
					end else begin
						if (t.write_byte[0])
							shift_bits[shift_len] = 1'b1;
						if (shift_len == SHIFT_LAST) begin
							serial_bank[t.bus_addr[14:13]] = shift_bits;
							r.reg_loaded = 1'b1;
							shift_bits = '0;
							shift_len = '0;
						end else begin
							shift_len = shift_len + 3'd1;
						end
					end
				end else if (cfg_shadow.mapper_type == MAPPER_LATCH) begin
					r.ok = 1'b1;
					if (t.bus_addr < LATCH_LIMIT)
						latched_bank = t.write_byte[4:0];
				end
			end
			CMD_CHR_READ: begin
				if (t.bus_addr >= CHR_WINDOW_END) begin
					r.ok = 1'b1;
					r.blank_read = 1'b1;
				end else begin
					low_table = t.bus_addr < CHR_TABLE_BYTES;
					a = low_table ? t.bus_addr : t.bus_addr - CHR_TABLE_BYTES;
					page = low_table ? cfg_shadow.chr_low_page : cfg_shadow.chr_high_page;
					mirror = serial_bank[SREG_CONTROL][1:0];
					if (!page[8]) begin
						a = (a + page[7:0] * PAGE_BYTES) & 32'hFFFF;
					end else if (cfg_shadow.mapper_type == MAPPER_SERIAL) begin
						if (low_table)
							bank = (mirror == MIRROR_SWAP_LOW) ? serial_bank[SREG_CHR1]
								: serial_bank[SREG_CHR0];
						else
							bank = (mirror == MIRROR_SWAP_HIGH) ? serial_bank[SREG_CHR0]
								: serial_bank[SREG_CHR1];
						a = (a + bank * BANK_BYTES) & 32'hFFFF;
					end
					if (a < cfg_shadow.chr_size_bytes) begin
						r.ok = 1'b1;
						r.rom_addr = 16'(a);
					end
				end
			end
			CMD_PRG_LOW: begin
				if (cfg_shadow.prg_bank_count >= 2) begin
					r.ok = 1'b1;
					r.rom_addr = 16'(t.bus_addr);
				end
			end
			CMD_PRG_HIGH: begin
				if (cfg_shadow.prg_bank_count >= 1) begin
					r.ok = 1'b1;
					r.rom_addr = (cfg_shadow.prg_bank_count >= 2)
						? 16'(t.bus_addr + PRG_UPPER_BASE) : 16'(t.bus_addr);
				end
			end
			default: ;
		endcase
		r.mirror_mode = serial_bank[SREG_CONTROL][1:0];
		return r;
	endfunction

	function automatic dir_row_t access_row(input logic [1:0] cmd, input logic [14:0] addr,
			input logic [7:0] data);
		dir_row_t r;
		r = '0;
		r.kind = ROW_ACCESS;
		r.acc = cbm_in_t'{cmd, addr, data};
		return r;
	endfunction

	function automatic dir_row_t checked_row(input logic [1:0] cmd, input logic [14:0] addr,
			input logic [7:0] data, input cbm_out_t want);
		dir_row_t r;
		r = access_row(cmd, addr, data);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic dir_row_t config_row(input logic [2:0] index, input logic [15:0] value);
		dir_row_t r;
		r = '0;
		r.kind = ROW_CONFIG;
		r.index = index;
		r.value = value;
		return r;
	endfunction

	function automatic cbm_in_t random_access();
		cbm_in_t     t;
		int unsigned pick;
		t.bus_addr = 15'($urandom);
		t.write_byte = 8'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			t.cmd = CMD_PRG_WRITE;
			if ($urandom_range(0, 15) != 0)
				t.write_byte[7] = 1'b0;
		end else if (pick < 8) begin
			t.cmd = CMD_CHR_READ;
			if ($urandom_range(0, 7) != 0)
				t.bus_addr[14:13] = 2'b00;
		end else begin
			t.cmd = (pick == 8) ? CMD_PRG_LOW : CMD_PRG_HIGH;
		end
		return t;
	endfunction

	task automatic report_mismatch(input string field, input logic [15:0] got,
			input logic [15:0] want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s mismatch, got %0h expected %0h", $time, field, got, want);
	endtask

	task automatic send_access(input cbm_in_t t, input logic typed, input cbm_out_t want);
		cbm_out_t predicted;
		in_valid <= 1'b1;
		in_data <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = translate_access(t);
		expected_results.push_back(typed ? want : predicted);
		accesses_sent++;
	endtask

	task automatic pause(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] index, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (index)
			CFG_MAPPER_TYPE:    cfg_shadow.mapper_type = value[7:0];
			CFG_PRG_BANK_COUNT: cfg_shadow.prg_bank_count = value[7:0];
			CFG_CHR_SIZE_BYTES: cfg_shadow.chr_size_bytes = value;
			CFG_CHR_LOW_PAGE:   cfg_shadow.chr_low_page = value[8:0];
			CFG_CHR_HIGH_PAGE:  cfg_shadow.chr_high_page = value[8:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic run_phase(input logic [7:0] mapper, input logic [7:0] banks,
			input logic [15:0] chr_bytes, input logic [15:0] low_page,
			input logic [15:0] high_page, input int items);
		int burst_left;
		drain_results();
		cfg_write(CFG_MAPPER_TYPE, {8'($urandom), mapper});
		cfg_write(CFG_PRG_BANK_COUNT, {8'($urandom), banks});
		cfg_write(CFG_CHR_SIZE_BYTES, chr_bytes);
		cfg_write(CFG_CHR_LOW_PAGE, low_page);
		cfg_write(CFG_CHR_HIGH_PAGE, high_page);
		cfg_valid <= 1'b0;
		settings_used++;
		burst_left = $urandom_range(0, 8);
		for (int i = 0; i < items; i++) begin
			send_access(random_access(), 1'b0, '0);
			if (burst_left == 0) begin
				pause($urandom_range(1, 5));
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
					: $urandom_range(0, 8);
			end else begin
				burst_left--;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, rom_addr", out_data.rom_addr, '0);
			end else begin
				oldest_result = expected_results.pop_front();
				results_seen++;
				if (out_data.ok !== oldest_result.ok)
					report_mismatch("ok", out_data.ok, oldest_result.ok);
				if (out_data.rom_addr !== oldest_result.rom_addr)
					report_mismatch("rom_addr", out_data.rom_addr, oldest_result.rom_addr);
				if (out_data.blank_read !== oldest_result.blank_read)
					report_mismatch("blank_read", out_data.blank_read, oldest_result.blank_read);
				if (out_data.reg_loaded !== oldest_result.reg_loaded)
					report_mismatch("reg_loaded", out_data.reg_loaded, oldest_result.reg_loaded);
				if (out_data.mirror_mode !== oldest_result.mirror_mode)
					report_mismatch("mirror_mode", out_data.mirror_mode,
						oldest_result.mirror_mode);
			end
		end
		if (stall_left == 0) begin
			stall_mode = stall_pattern_e'($urandom_range(0, 3));
			stall_left = $urandom_range(16, 128);
		end
		stall_left--;
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
			default:     out_stall <= (stall_left % 4 != 0);
		endcase
	end

	initial begin
		logic [7:0]  mapper_pick;
		logic [7:0]  banks_pick;
		logic [15:0] size_pick;
		logic [15:0] low_pick;
		logic [15:0] high_pick;
		logic        cfg_open;
		cfg_shadow = '0;
		cfg_shadow.chr_low_page = PAGE_NONE;
		cfg_shadow.chr_high_page = PAGE_NONE;
		shift_bits = '0;
		shift_len = '0;
		latched_bank = '0;
		foreach (serial_bank[i])
			serial_bank[i] = '0;
		cfg_open = 1'b0;
		dir_table = '{
			checked_row(CMD_PRG_LOW, 15'h0000, 8'h00, REFUSED),
			checked_row(CMD_PRG_HIGH, 15'h7FFF, 8'hFF, REFUSED),
			checked_row(CMD_CHR_READ, 15'h7FFF, 8'h00, cbm_out_t'{1'b1, 16'h0, 1'b1, 1'b0, 2'd0}),
			checked_row(CMD_CHR_READ, 15'h0000, 8'h00, REFUSED),
			checked_row(CMD_PRG_WRITE, 15'h0000, 8'h01, REFUSED),
			config_row(CFG_MAPPER_TYPE, 16'h0001),
			config_row(CFG_PRG_BANK_COUNT, 16'h0001),
			config_row(CFG_CHR_SIZE_BYTES, 16'hFFFF),
			checked_row(CMD_PRG_HIGH, 15'h7FFF, 8'h00,
				cbm_out_t'{1'b1, 16'h7FFF, 1'b0, 1'b0, 2'd0}),
			checked_row(CMD_PRG_LOW, 15'h7FFF, 8'h00, REFUSED),
			access_row(CMD_PRG_WRITE, 15'h0000, 8'h01),
			access_row(CMD_PRG_WRITE, 15'h0000, 8'h80),
			access_row(CMD_PRG_WRITE, 15'h0000, 8'h01),
			access_row(CMD_PRG_WRITE, 15'h0000, 8'h7F),
			access_row(CMD_PRG_WRITE, 15'h0000, 8'h00),
			access_row(CMD_PRG_WRITE, 15'h0000, 8'h7E),
			checked_row(CMD_PRG_WRITE, 15'h0000, 8'h00,
				cbm_out_t'{1'b1, 16'h0, 1'b0, 1'b1, 2'd3}),
			access_row(CMD_PRG_WRITE, 15'h3FFF, 8'h7F),
			access_row(CMD_PRG_WRITE, 15'h3FFF, 8'h7F),
			access_row(CMD_PRG_WRITE, 15'h3FFF, 8'h7F),
			access_row(CMD_PRG_WRITE, 15'h3FFF, 8'h7F),
			checked_row(CMD_PRG_WRITE, 15'h3FFF, 8'h7F,
				cbm_out_t'{1'b1, 16'h0, 1'b0, 1'b1, 2'd3}),
			access_row(CMD_CHR_READ, 15'h0000, 8'h00),
			access_row(CMD_CHR_READ, 15'h1FFF, 8'h00),
			config_row(CFG_CHR_LOW_PAGE, 16'h00FF),
			config_row(CFG_CHR_HIGH_PAGE, 16'h0000),
			access_row(CMD_CHR_READ, 15'h0FFF, 8'h00),
			access_row(CMD_CHR_READ, 15'h1000, 8'h00),
			config_row(CFG_MAPPER_TYPE, 16'h0002),
			config_row(CFG_PRG_BANK_COUNT, 16'h00FF),
			config_row(CFG_CHR_SIZE_BYTES, 16'h2000),
			config_row(CFG_CHR_LOW_PAGE, 16'h01FF),
			config_row(CFG_CHR_HIGH_PAGE, 16'hFFFF),
			config_row(CFG_UNUSED, 16'hFFFF),
			access_row(CMD_PRG_WRITE, 15'h1FFF, 8'h1F),
			access_row(CMD_PRG_WRITE, 15'h2000, 8'hFF),
			access_row(CMD_CHR_READ, 15'h1FFF, 8'h00),
			checked_row(CMD_PRG_HIGH, 15'h7FFF, 8'h00,
				cbm_out_t'{1'b1, 16'hBFFF, 1'b0, 1'b0, 2'd3}),
			config_row(CFG_MAPPER_TYPE, 16'h00FF),
			checked_row(CMD_PRG_WRITE, 15'h0000, 8'h00,
				cbm_out_t'{1'b0, 16'h0, 1'b0, 1'b0, 2'd3})
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[r]) begin
			if (dir_table[r].kind == ROW_CONFIG) begin
				if (!cfg_open)
					drain_results();
				cfg_write(dir_table[r].index, dir_table[r].value);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open) begin
					cfg_valid <= 1'b0;
					cfg_open = 1'b0;
					settings_used++;
				end
				send_access(dir_table[r].acc, dir_table[r].typed, dir_table[r].want);
			end
		end

		for (int p = 0; p < 7; p++) begin
			case ($urandom_range(0, 7))
				5:       mapper_pick = MAPPER_LATCH;
				6:       mapper_pick = 8'h00;
				7:       mapper_pick = 8'($urandom_range(3, 255));
				default: mapper_pick = MAPPER_SERIAL;
			endcase
			if (p < 2)
				mapper_pick = MAPPER_SERIAL;
			case ($urandom_range(0, 3))
				0:       banks_pick = 8'd0;
				1:       banks_pick = 8'd1;
				2:       banks_pick = 8'd2;
				default: banks_pick = 8'($urandom);
			endcase
			case ($urandom_range(0, 3))
				0:       size_pick = 16'hFFFF;
				1:       size_pick = 16'h2000;
				2:       size_pick = 16'h8000;
				default: size_pick = 16'($urandom);
			endcase
			low_pick = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 255))
				: {7'($urandom), PAGE_NONE};
			high_pick = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 255))
				: {7'($urandom), PAGE_NONE};
			run_phase(mapper_pick, banks_pick, size_pick, low_pick, high_pick, 200);
		end
		run_phase(8'hFF, 8'hFF, 16'hFFFF, 16'h00FF, 16'h00FF, 100);
		run_phase(8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 100);
		drain_results();

		$display("Sent %0d bus accesses and %0d register writes under %0d settings.",
			accesses_sent, reg_writes, settings_used);
		$display("Compared %0d results; %0d field mismatches.", results_seen, mismatches);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Timed out with %0d results outstanding", expected_results.size());
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: files.f
rtl/core/cbm_pkg.sv
rtl/core/cbm_cfg.sv
rtl/core/cbm_serial.sv
rtl/core/cbm_xlate.sv
rtl/core/cartridge_bank_mapper_core.sv
tb/testbench.sv
